FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the scheduler rtl; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition must hold at every clock edge out of reset
`define SSTF_ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next
`define SSTF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SSTF_ASSERT_NOW(lbl, clk, rst_n, prop, msg)
`define SSTF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: src/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg
// word types, per-cell control and constants of the seek scheduler
// ----------------------------------------------------------------------------
package sstf_pkg;

	// request word
	typedef struct packed {
		logic [15:0] track;
		logic [15:0] head_start;
		logic        last;
	} req_word_t;

	// result word
	typedef struct packed {
		logic [15:0] served_track;
		logic [15:0] seek_distance;
		logic [21:0] total_distance;
		logic        overflow;
		logic        final_res;
	} res_word_t;

	// control broadcast to one cell
	typedef struct packed {
		logic active;  // cell holds a request of the current batch
		logic wr_en;   // load the request track into this cell
		logic mark;    // this cell won the last search
		logic clear;   // end of batch, drop served flag
	} cell_ctrl_t;

	localparam logic [15:0] SEEK_MAX  = 16'hFFFF;
	localparam logic [21:0] TOTAL_MAX = 22'h3FFFFF;

endpackage

FILE: src/sstf_cell.sv
// ----------------------------------------------------------------------------
// sstf_cell
// one request slot of the search row: holds a track and its served flag,
// and passes the best candidate so far on to the next cell each cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sstf_cell #(
	parameter int TRACK_BITS = 16,
	parameter int IDX_W      = 6,
	parameter int INDEX      = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sstf_pkg::cell_ctrl_t   ctrl,
	input  logic [TRACK_BITS-1:0]  wr_track,
	input  logic [TRACK_BITS-1:0]  head,
	// candidate from the previous cell
	input  logic                   cand_in_valid,
	input  logic                   cand_in_found,
	input  logic [TRACK_BITS-1:0]  cand_in_dist,
	input  logic [TRACK_BITS-1:0]  cand_in_track,
	input  logic [IDX_W-1:0]       cand_in_idx,
	// candidate to the next cell
	output logic                   cand_out_valid,
	output logic                   cand_out_found,
	output logic [TRACK_BITS-1:0]  cand_out_dist,
	output logic [TRACK_BITS-1:0]  cand_out_track,
	output logic [IDX_W-1:0]       cand_out_idx
);

	logic [TRACK_BITS-1:0] track_q;
	logic                  served_q;
	logic [TRACK_BITS-1:0] own_dist;
	logic                  take;
	logic                  valid_q;
	logic                  found_q;
	logic [TRACK_BITS-1:0] dist_q;
	logic [TRACK_BITS-1:0] ctrack_q;
	logic [IDX_W-1:0]      idx_q;

	// stored request track
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			track_q <= wr_track;
		end
	end

	// served flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			served_q <= 1'b0;
		end else if (ctrl.clear || ctrl.wr_en) begin
			served_q <= 1'b0;
		end else if (ctrl.mark) begin
			served_q <= 1'b1;
		end
	end

	// distance from head, strict compare keeps the earlier cell on a tie
	assign own_dist = (head >= track_q) ? (head - track_q) : (track_q - head);
	assign take = ctrl.active && !served_q && (!cand_in_found || own_dist < cand_in_dist);

	// candidate stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			valid_q <= cand_in_valid;
			found_q <= cand_in_found || (cand_in_valid && take);
		end
	end

	// candidate stage payload
	always_ff @(posedge clk) begin
		if (cand_in_valid && take) begin
			dist_q   <= own_dist;
			ctrack_q <= track_q;
			idx_q    <= IDX_W'(INDEX);
		end else begin
			dist_q   <= cand_in_dist;
			ctrack_q <= cand_in_track;
			idx_q    <= cand_in_idx;
		end
	end

	assign cand_out_valid = valid_q;
	assign cand_out_found = found_q;
	assign cand_out_dist  = dist_q;
	assign cand_out_track = ctrack_q;
	assign cand_out_idx   = idx_q;

	`SSTF_ASSERT_NOW(a_mark_unserved, clk, arst_n,
		!ctrl.mark || (ctrl.active && !served_q), "cell marked while empty or already served")
	`SSTF_ASSERT_NEXT(a_clear_flag, clk, arst_n,
		ctrl.clear, !served_q, "served flag survived batch end")
	`SSTF_ASSERT_NEXT(a_take_found, clk, arst_n,
		cand_in_valid && take, cand_out_valid && cand_out_found, "taken candidate not passed on")

endmodule

FILE: src/sstf_disk_scheduler.sv
// ----------------------------------------------------------------------------
// sstf_disk_scheduler
// shortest seek first scheduler over a row of request cells
// ----------------------------------------------------------------------------
// Request words are taken one per cycle while a batch loads; a word with last
// set also gives the start head and begins the burst of results. Words past
// MAX_REQUESTS are dropped and flag overflow on every result of the batch.
// Each result comes from one search pass that walks a candidate through the
// row of MAX_REQUESTS cells, one cell per cycle, and the next pass starts
// only once that result is registered; no request word is taken during the burst.
// Ties in distance go to the request loaded first. No clearing pass follows
// reset.
`include "assert_macros.svh"

module sstf_disk_scheduler #(
	parameter int MAX_REQUESTS = 64,
	parameter int TRACK_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  sstf_pkg::req_word_t   req_word,
	output logic                  res_valid,
	input  logic                  res_stall,
	output sstf_pkg::res_word_t   res_word
);

	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int SUM_W = ((TRACK_BITS > 22) ? TRACK_BITS : 22) + 1;

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      pos_q;
	logic                  ovf_q;
	logic [TRACK_BITS-1:0] head_q;
	logic [21:0]           total_q;
	logic                  start_q;
	logic [TRACK_BITS-1:0] pick_track_q;
	logic [TRACK_BITS-1:0] pick_dist_q;
	logic [IDX_W-1:0]      pick_idx_q;
	logic                  res_valid_q;
	sstf_pkg::res_word_t   res_q;

	logic                  req_fire;
	logic                  store_full;
	logic                  emit_fire;
	logic                  final_pos;
	logic [31:0]           trk_ext;
	logic [31:0]           hs_ext;
	logic [TRACK_BITS-1:0] trk;
	logic [TRACK_BITS-1:0] hs;
	logic [31:0]           pick_track_ext;
	logic [31:0]           pick_dist_ext;
	logic [15:0]           seek;
	logic [SUM_W-1:0]      sum;
	logic [21:0]           total_next;

	sstf_pkg::cell_ctrl_t  ctrl [MAX_REQUESTS];
	logic                  ch_valid [MAX_REQUESTS+1];
	logic                  ch_found [MAX_REQUESTS+1];
	logic [TRACK_BITS-1:0] ch_dist  [MAX_REQUESTS+1];
	logic [TRACK_BITS-1:0] ch_track [MAX_REQUESTS+1];
	logic [IDX_W-1:0]      ch_idx   [MAX_REQUESTS+1];

	// handshake
	assign req_stall  = (state_q != ST_LOAD);
	assign req_fire   = req_valid && !req_stall;
	assign res_valid  = res_valid_q;
	assign res_word   = res_q;
	assign store_full = (count_q == CNT_W'(MAX_REQUESTS));
	assign emit_fire  = (state_q == ST_EMIT) && (!res_valid_q || !res_stall);
	assign final_pos  = (CNT_W'(pos_q + 1'b1) == count_q);

	// input tracks cut to the track width
	assign trk_ext = 32'(req_word.track);
	assign hs_ext  = 32'(req_word.head_start);
	assign trk     = trk_ext[TRACK_BITS-1:0];
	assign hs      = hs_ext[TRACK_BITS-1:0];

	// result fields with saturation
	assign pick_track_ext = 32'(pick_track_q);
	assign pick_dist_ext  = 32'(pick_dist_q);
	assign seek = (pick_dist_ext > 32'(sstf_pkg::SEEK_MAX)) ? sstf_pkg::SEEK_MAX
		: pick_dist_ext[15:0];
	assign sum = SUM_W'(total_q) + SUM_W'(pick_dist_q);
	assign total_next = (sum > SUM_W'(sstf_pkg::TOTAL_MAX)) ? sstf_pkg::TOTAL_MAX
		: sum[21:0];

	// search launch into the first cell
	assign ch_valid[0] = start_q;
	assign ch_found[0] = 1'b0;
	assign ch_dist[0]  = '0;
	assign ch_track[0] = '0;
	assign ch_idx[0]   = '0;

	// row of request cells
	for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
		assign ctrl[i].active = (count_q > CNT_W'(i));
		assign ctrl[i].wr_en  = req_fire && !store_full
			&& (count_q[IDX_W-1:0] == IDX_W'(i));
		assign ctrl[i].mark   = emit_fire && (pick_idx_q == IDX_W'(i));
		assign ctrl[i].clear  = emit_fire && final_pos;

		sstf_cell #(
			.TRACK_BITS (TRACK_BITS),
			.IDX_W      (IDX_W),
			.INDEX      (i)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctrl           (ctrl[i]),
			.wr_track       (trk),
			.head           (head_q),
			.cand_in_valid  (ch_valid[i]),
			.cand_in_found  (ch_found[i]),
			.cand_in_dist   (ch_dist[i]),
			.cand_in_track  (ch_track[i]),
			.cand_in_idx    (ch_idx[i]),
			.cand_out_valid (ch_valid[i+1]),
			.cand_out_found (ch_found[i+1]),
			.cand_out_dist  (ch_dist[i+1]),
			.cand_out_track (ch_track[i+1]),
			.cand_out_idx   (ch_idx[i+1])
		);
	end

	// search launch after the last request word or after each non-final result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= (req_fire && req_word.last) || (emit_fire && !final_pos);
		end
	end

	// sequencer and batch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
			head_q  <= '0;
			total_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (req_fire) begin
						if (!store_full) begin
							count_q <= CNT_W'(count_q + 1'b1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (req_word.last) begin
							head_q  <= hs;
							total_q <= '0;
							pos_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (ch_valid[MAX_REQUESTS]) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						if (final_pos) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							total_q <= '0;
							head_q  <= pick_track_q;
							state_q <= ST_LOAD;
						end else begin
							total_q <= total_next;
							head_q  <= pick_track_q;
							pos_q   <= CNT_W'(pos_q + 1'b1);
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// winner of the search pass
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && ch_valid[MAX_REQUESTS]) begin
			pick_track_q <= ch_track[MAX_REQUESTS];
			pick_dist_q  <= ch_dist[MAX_REQUESTS];
			pick_idx_q   <= ch_idx[MAX_REQUESTS];
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			res_q.served_track   <= pick_track_ext[15:0];
			res_q.seek_distance  <= seek;
			res_q.total_distance <= total_next;
			res_q.overflow       <= ovf_q;
			res_q.final_res      <= final_pos;
		end
	end

	`SSTF_ASSERT_NOW(a_tail_in_scan, clk, arst_n,
		!ch_valid[MAX_REQUESTS] || state_q == ST_SCAN, "search result outside a scan")
	`SSTF_ASSERT_NOW(a_tail_found, clk, arst_n,
		!ch_valid[MAX_REQUESTS] || ch_found[MAX_REQUESTS], "search pass found no unserved request")
	`SSTF_ASSERT_NOW(a_batch_nonempty, clk, arst_n,
		state_q == ST_LOAD || count_q != '0, "scheduling with an empty store")
	`SSTF_ASSERT_NEXT(a_batch_end, clk, arst_n, emit_fire && final_pos,
		count_q == '0 && state_q == ST_LOAD, "batch state not cleared after last result")

endmodule

FILE: tb/tb_sstf_disk_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sstf_disk_scheduler
// self-checking testbench of the shortest seek first scheduler
// ----------------------------------------------------------------------------
// Request words go in as batches. A scoreboard builds the expected seek order
// of each batch on the word marked last and checks every result word against
// it, field by field. A short directed part covers track extremes, distance
// ties, repeated tracks and zero seeks. Random batches follow under several
// sender and receiver idling mixes. A final phase holds the result side off
// for a long stretch while full and overflowing batches are offered.

module tb_sstf_disk_scheduler;

	localparam int CLK_PERIOD  = 12;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_WAIT  = 200;

	// scoreboard: predicts the seek order of a batch and checks result words
	class sstf_scoreboard;
		localparam int STORE_DEPTH = 64;

		logic [15:0]         stored_track [STORE_DEPTH];
		int unsigned         stored_count;
		bit                  dropped_seen;
		sstf_pkg::res_word_t schedule_q [$];
		int unsigned         errors;
		int unsigned         results_seen;
		int unsigned         batches_done;
		int unsigned         dropped_batches;

		function new();
			stored_count    = 0;
			dropped_seen    = 1'b0;
			errors          = 0;
			results_seen    = 0;
			batches_done    = 0;
			dropped_batches = 0;
		endfunction

		function int unsigned pending();
			return schedule_q.size();
		endfunction

		// store one accepted request word, build the schedule on the last one
		function void note_request(sstf_pkg::req_word_t w);
			bit                  served [STORE_DEPTH];
			logic [15:0]         head;
			int unsigned         total, best, best_d, d;
			bit                  found;
			sstf_pkg::res_word_t r;

			if (stored_count < STORE_DEPTH) begin
				stored_track[stored_count] = w.track;
				stored_count++;
			end else begin
				dropped_seen = 1'b1;
			end
			if (!w.last)
				return;

			head  = w.head_start;
			total = 0;
			foreach (served[i])
				served[i] = 1'b0;
			for (int k = 0; k < stored_count; k++) begin
				found  = 1'b0;
				best   = 0;
				best_d = 0;
				// nearest unserved request, earliest one on a tie
				for (int i = 0; i < stored_count; i++) begin
					if (served[i])
						continue;
					d = (head >= stored_track[i]) ? head - stored_track[i]
						: stored_track[i] - head;
					if (!found || d < best_d) begin
						found  = 1'b1;
						best   = i;
						best_d = d;
					end
				end
				served[best] = 1'b1;
				head  = stored_track[best];
				total = total + best_d;
				if (total > sstf_pkg::TOTAL_MAX)
					total = sstf_pkg::TOTAL_MAX;
				r.served_track   = head;
				r.seek_distance  = (best_d > sstf_pkg::SEEK_MAX) ? sstf_pkg::SEEK_MAX
					: best_d[15:0];
				r.total_distance = total[21:0];
				r.overflow       = dropped_seen;
				r.final_res      = (k + 1 == stored_count);
				schedule_q.push_back(r);
			end
			batches_done++;
			if (dropped_seen)
				dropped_batches++;
			stored_count = 0;
			dropped_seen = 1'b0;
		endfunction

		function void check_field(string field, logic [21:0] exp_v, logic [21:0] got_v);
			if (got_v !== exp_v) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
					$time, field, exp_v, got_v);
			end
		endfunction

		// compare one result word with the oldest expected one
		function void check_result(sstf_pkg::res_word_t got);
			sstf_pkg::res_word_t exp_w;

			results_seen++;
			if (schedule_q.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result word, expected none, actual %p",
					$time, got);
				return;
			end
			exp_w = schedule_q.pop_front();
			check_field("served_track", exp_w.served_track, got.served_track);
			check_field("seek_distance", exp_w.seek_distance, got.seek_distance);
			check_field("total_distance", exp_w.total_distance, got.total_distance);
			check_field("overflow", exp_w.overflow, got.overflow);
			check_field("final_res", exp_w.final_res, got.final_res);
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	sstf_pkg::req_word_t req_word  = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	sstf_pkg::res_word_t res_word;

	sstf_scoreboard sb = new();

	int unsigned idle_pct   = 0;
	int unsigned stall_pct  = 0;
	int unsigned items_sent = 0;
	int unsigned hold_seq   = 0;
	int unsigned hold_seen  = 0;
	int unsigned hold_cnt   = 0;

	sstf_disk_scheduler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// result side: check accepted words, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res_word);
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_cnt  = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// offer one request word and wait until it is taken
	task automatic send_word(input logic [15:0] trk, input logic [15:0] hs, input logic lst);
		sstf_pkg::req_word_t w;

		w.track      = trk;
		w.head_start = hs;
		w.last       = lst;
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(w);
		items_sent++;
	endtask

	// one batch of n requests with random content
	task automatic random_batch(input int n);
		logic [15:0] base;
		logic [15:0] trk;
		logic [15:0] head;
		int          style;

		style = $urandom_range(3);
		base  = 16'($urandom);
		// clustered batches get a head near the cluster
		head  = (style >= 2) ? base + 16'($urandom_range(31)) : 16'($urandom);
		for (int i = 0; i < n; i++) begin
			case (style)
				2:       trk = base + 16'($urandom_range(31));
				3:       trk = base + 16'($urandom_range(3)) * 16'd8;  // ties and repeats
				default: trk = 16'($urandom);
			endcase
			if (i == n - 1)
				send_word(trk, head, 1'b1);
			else
				send_word(trk, 16'($urandom), 1'b0);
		end
	endtask

	// mostly small batches, a few near or beyond capacity
	function automatic int pick_batch_size();
		int r;

		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(10, 1);
		else if (r < 95)
			return $urandom_range(40, 11);
		return $urandom_range(70, 60);
	endfunction

	task automatic random_phase(input int unsigned idle, input int unsigned stall,
		input int unsigned count);
		int unsigned target;

		idle_pct  = idle;
		stall_pct = stall;
		target    = items_sent + count;
		while (items_sent < target)
			random_batch(pick_batch_size());
	endtask

	// main sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: track extremes, full-range seeks
		send_word(16'd0, 16'hFFFF, 1'b1);
		send_word(16'hFFFF, 16'd0, 1'b1);
		// tie on distance, earliest loaded wins, either order
		send_word(16'd110, 16'hFFFF, 1'b0);
		send_word(16'd90, 16'd100, 1'b1);
		send_word(16'd90, 16'hFFFF, 1'b0);
		send_word(16'd110, 16'd100, 1'b1);
		// repeated tracks and zero seeks
		send_word(16'd500, 16'h0000, 1'b0);
		send_word(16'd500, 16'hFFFF, 1'b0);
		send_word(16'd200, 16'd500, 1'b1);
		// mixed extremes
		send_word(16'hFFFF, 16'hAAAA, 1'b0);
		send_word(16'd0, 16'h5555, 1'b0);
		send_word(16'h8000, 16'd0, 1'b0);
		send_word(16'd1, 16'hFFFF, 1'b0);
		send_word(16'h7FFF, 16'h7FFF, 1'b1);
		// head already on the request
		send_word(16'd1234, 16'd1234, 1'b1);

		// random batches under the idling mixes
		random_phase(0, 0, 70);
		random_phase(52, 0, 70);
		random_phase(0, 52, 70);
		random_phase(24, 24, 70);

		// long hold-off on results while full and overflowing batches arrive
		idle_pct  = 0;
		stall_pct = 0;
		hold_seq++;
		random_batch(66);
		random_batch(64);
		random_batch(3);

		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("sent %0d request words in %0d batches, %0d of them with dropped requests",
			items_sent, sb.batches_done, sb.dropped_batches);
		$display("checked %0d result words under four idling mixes and one long hold-off",
			sb.results_seen);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#8_000_000;
		$display("timeout with %0d result words still expected", sb.pending());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
